// ===== rtl/bsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants
// constants and the datapath operation codes used by the sequencer and alu
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW = 5;

  localparam logic [DataW-1:0] C3038 = 32'd3038;
  localparam logic [DataW-1:0] CM7357 = 32'hFFFF_E343;
  localparam logic [DataW-1:0] C3791 = 32'd3791;
  localparam logic [DataW-1:0] C50000 = 32'd50000;
  localparam logic [DataW-1:0] C4000 = 32'd4000;
  localparam logic [DataW-1:0] C32768 = 32'd32768;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_MULH = 2'd2
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

// ===== rtl/bsc_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_alu: bit-serial multiply and divide unit
// one bit per cycle; mul gives low 32 bits, mulh gives bits 46:15 of the
// 64-bit unsigned product, div gives the unsigned quotient
// ----------------------------------------------------------------------------
module bsc_alu (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bsc_pkg::alu_req_t           req,
  input  logic [bsc_pkg::DataW-1:0]   a,
  input  logic [bsc_pkg::DataW-1:0]   b,
  output bsc_pkg::alu_sts_t           sts,
  output logic [bsc_pkg::DataW-1:0]   res
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  bsc_pkg::op_t                op_r, op_nxt;
  logic [bsc_pkg::CntW-1:0]    cnt_r, cnt_nxt;
  logic [63:0]                 acc_r, acc_nxt;
  logic [bsc_pkg::DataW-1:0]   sh_r, sh_nxt;
  logic [bsc_pkg::DataW-1:0]   dv_r, dv_nxt;
  logic [32:0]                 rem_sh;
  logic [32:0]                 rem_sub;

  assign rem_sh  = {acc_r[31:0], sh_r[31]};
  assign rem_sub = rem_sh - {1'b0, dv_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    dv_nxt   = dv_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      sh_nxt   = a;
      dv_nxt   = b;
    end else if (busy_r) begin
      if (op_r == bsc_pkg::OP_DIV) begin
        // restoring division, dividend bits shifted out of sh_r
        if (!rem_sub[32]) begin
          acc_nxt = {32'd0, rem_sub[31:0]};
          sh_nxt  = {sh_r[30:0], 1'b1};
        end else begin
          acc_nxt = {32'd0, rem_sh[31:0]};
          sh_nxt  = {sh_r[30:0], 1'b0};
        end
      end else begin
        // shift-add, multiplier bits taken lsb first
        acc_nxt = acc_r + ({32'd0, sh_r[0] ? dv_r : 32'd0} << cnt_r);
        sh_nxt  = {1'b0, sh_r[31:1]};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    dv_r  <= dv_nxt;
  end

  always_comb begin
    case (op_r)
      bsc_pkg::OP_DIV:  res = sh_r;
      bsc_pkg::OP_MULH: res = acc_r[46:15];
      default:          res = acc_r[31:0];
    endcase
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("start while busy");
  a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> cnt_r == '0) else $error("count not cleared");

endmodule

// ===== rtl/barometric_sensor_compensation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_unit: integer barometer compensation
// temperature and pressure compensation with a shared bit-serial mul/div
// ----------------------------------------------------------------------------
// channel  direction  payload
// in_      slave      tdata = raw_sample[18:0]; tuser = kind
// out_     master     tdata = value[31:0]; tuser = {divide_fault, kind_out}
// cfg_     write      index 0..4, data 48 bits
//
// every multiply and divide runs on one serial unit: the sequencer issues it,
// waits while the unit is busy and takes the result on done; a temperature
// request is one multiply and one divide, a pressure request is ten
// multiplies and one divide
// one request in flight; in_tready is low from accept until the result is
// taken, so a new request is not accepted before the last result is taken
// synchronous active-low reset clears control state, config and temp_term
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // raw_sample [18:0], zero fill above
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value [31:0]
  output logic [1:0]  out_tuser,  // kind_out [0], divide_fault [1]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  typedef enum logic [2:0] {
    CFG_OSS = 3'd0,
    CFG_A1  = 3'd1,
    CFG_A2  = 3'd2,
    CFG_B   = 3'd3,
    CFG_M   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_t;

  // config registers
  logic [1:0]  oss_r;
  logic [47:0] ca1_r, ca2_r;
  logic [31:0] cb_r, cm_r;
  logic [31:0] term_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oss_r <= '0; ca1_r <= '0; ca2_r <= '0; cb_r <= '0; cm_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OSS: oss_r <= cfg_wdata[1:0];
        CFG_A1:  ca1_r <= cfg_wdata;
        CFG_A2:  ca2_r <= cfg_wdata;
        CFG_B:   cb_r  <= cfg_wdata[31:0];
        CFG_M:   cm_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // coefficients
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ca1_r[47]}}, ca1_r[47:32]};
  assign ac2 = {{16{ca1_r[31]}}, ca1_r[31:16]};
  assign ac3 = {{16{ca1_r[15]}}, ca1_r[15:0]};
  assign ac4 = {16'd0, ca2_r[47:32]};
  assign ac5 = {16'd0, ca2_r[31:16]};
  assign ac6 = {16'd0, ca2_r[15:0]};
  assign b1  = {{16{cb_r[31]}}, cb_r[31:16]};
  assign b2  = {{16{cb_r[15]}}, cb_r[15:0]};
  assign mc  = {{16{cm_r[31]}}, cm_r[31:16]};
  assign md  = {{16{cm_r[15]}}, cm_r[15:0]};

  state_t               state_r, state_nxt;
  logic [3:0]           step_r, step_nxt;
  logic                 kind_r, kind_nxt;
  logic [31:0]          raw_r, raw_nxt;
  logic [31:0]          t0_r, t0_nxt;   // x1 / b3
  logic [31:0]          t1_r, t1_nxt;   // sq / b7 / p
  logic [31:0]          t2_r, t2_nxt;   // x1 accumulator
  logic [31:0]          t3_r, t3_nxt;   // second accumulator
  logic                 neg_r, neg_nxt;
  logic [31:0]          val_r, val_nxt;
  logic                 flt_r, flt_nxt;
  logic [31:0]          term_nxt;
  logic                 ovld_r, ovld_nxt;

  bsc_pkg::alu_req_t    req;
  bsc_pkg::alu_sts_t    sts;
  logic [31:0]          op_a, op_b, res;

  bsc_alu u_alu (
    .clk(clk), .rst_n(rst_n), .req(req), .a(op_a), .b(op_b), .sts(sts), .res(res)
  );

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
    asr = 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? 32'(0 - v) : v;
  endfunction

  logic [31:0] d_t, b6, b7, b3v, x3a, pfin;
  assign d_t = t0_r + md;
  assign b6  = term_r - bsc_pkg::C4000;

  // request issue: per step, choose operands
  always_comb begin
    req.start = 1'b0;
    req.op    = bsc_pkg::OP_MUL;
    op_a      = '0;
    op_b      = '0;
    if (state_r == ST_ISSUE) begin
      req.start = 1'b1;
      if (!kind_r) begin
        case (step_r)
          4'd0: begin op_a = raw_r - ac6; op_b = ac5; end
          default: begin req.op = bsc_pkg::OP_DIV; op_a = mag(mc << 11); op_b = mag(d_t); end
        endcase
      end else begin
        case (step_r)
          4'd0: begin op_a = b6; op_b = b6; end
          4'd1: begin op_a = b2; op_b = t1_r; end
          4'd2: begin op_a = ac2; op_b = b6; end
          4'd3: begin op_a = ac3; op_b = b6; end
          4'd4: begin op_a = b1; op_b = t1_r; end
          4'd5: begin req.op = bsc_pkg::OP_MULH; op_a = ac4; op_b = t3_r; end
          4'd6: begin op_a = raw_r - t0_r; op_b = bsc_pkg::C50000 >> oss_r; end
          4'd7: begin req.op = bsc_pkg::OP_DIV;
                      op_a = t1_r[31] ? t1_r : (t1_r << 1); op_b = t2_r; end
          4'd8: begin op_a = asr(t1_r, 5'd8); op_b = asr(t1_r, 5'd8); end
          4'd9: begin op_a = t2_r; op_b = bsc_pkg::C3038; end
          default: begin op_a = bsc_pkg::CM7357; op_b = t1_r; end
        endcase
      end
    end
  end

  assign x3a  = t2_r + asr(res, 5'd16);
  assign b3v  = asr(((ac1 << 2) + t2_r + asr(res, 5'd11)) << oss_r, 5'd0) + 32'd2;
  assign b7   = res;
  assign pfin = t1_r + asr(t2_r + asr(res, 5'd16) + bsc_pkg::C3791, 5'd4);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    kind_nxt  = kind_r;
    raw_nxt   = raw_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    t2_nxt    = t2_r;
    t3_nxt    = t3_r;
    neg_nxt   = neg_r;
    val_nxt   = val_r;
    flt_nxt   = flt_r;
    term_nxt  = term_r;
    ovld_nxt  = ovld_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          raw_nxt   = {13'd0, in_tdata[18:0]};
          step_nxt  = '0;
          flt_nxt   = 1'b0;
          val_nxt   = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (sts.done) begin
          state_nxt = ST_ISSUE;
          step_nxt  = step_r + 1'b1;
          if (!kind_r) begin
            if (step_r == 4'd0) begin
              t0_nxt = asr(res, 5'd15);
              if (t0_nxt + md == 0) begin
                flt_nxt = 1'b1; state_nxt = ST_OUT;
              end
              neg_nxt = (mc[31] ^ 1'b0) != (t0_nxt + md >= 32'h8000_0000);
            end else begin
              term_nxt  = t0_r + (neg_r ? 32'(0 - res) : res);
              val_nxt   = asr(term_nxt + 32'd8, 5'd4);
              state_nxt = ST_OUT;
            end
          end else begin
            case (step_r)
              4'd0: t1_nxt = asr(res, 5'd12);
              4'd1: t2_nxt = asr(res, 5'd11);
              // x2 folds with step 1 x1 into x3 and b3; sq stays in t1
              4'd2: t0_nxt = asr(b3v, 5'd2);
              4'd3: t2_nxt = asr(res, 5'd13);
              4'd4: t3_nxt = asr(x3a + 32'd2, 5'd2) + bsc_pkg::C32768;
              4'd5: begin
                t2_nxt = res;
                if (res == 0) begin flt_nxt = 1'b1; state_nxt = ST_OUT; end
              end
              4'd6: t1_nxt = b7;
              4'd7: t1_nxt = t1_r[31] ? (res << 1) : res;
              4'd8: t2_nxt = res;
              4'd9: t2_nxt = asr(res, 5'd16);
              default: begin val_nxt = pfin; state_nxt = ST_OUT; end
            endcase
          end
        end
      end
      default: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
    endcase
    ovld_nxt = (state_nxt == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
      term_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      term_r  <= term_nxt;
    end
    step_r <= step_nxt;
    kind_r <= kind_nxt;
    raw_r  <= raw_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    t2_r   <= t2_nxt;
    t3_r   <= t3_nxt;
    neg_r  <= neg_nxt;
    val_r  <= val_nxt;
    flt_r  <= flt_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = val_r;
  assign out_tuser  = {flt_r, kind_r};

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == ST_OUT) else $error("valid outside output state");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tdata == 0) else $error("fault with value");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !in_tready) else $error("ready while busy");

endmodule
